/* rtl/tcr_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the console renderer.
`timescale 1ns / 1ps
package tcr_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int GSEL_W     = 8;
  localparam int GROW_W     = 5;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 2;
  localparam int PIX_W      = 13;
  localparam int CURSOR_W   = 17;
  localparam int COL_W      = 8;
  localparam int GDIM_W     = 6;
  localparam int COUNT_W    = 9;
  localparam int CELLS_W    = 16;
  localparam int CFG_IDX_W  = 3;

  // Default sizes of the glyph store
  localparam int DEF_MAX_GLYPHS       = 256;
  localparam int DEF_MAX_GLYPH_HEIGHT = 32;

  // Register reset values
  localparam logic [COL_W-1:0]   RST_COLS  = 8'd80;
  localparam logic [COL_W-1:0]   RST_ROWS  = 8'd25;
  localparam logic [GDIM_W-1:0]  RST_GW    = 6'd8;
  localparam logic [GDIM_W-1:0]  RST_GH    = 6'd16;
  localparam logic [COUNT_W-1:0] RST_COUNT = 9'd256;
  localparam logic [COL_W-1:0]   RST_TAB   = 8'd2;
  localparam logic [DATA_W-1:0]  RST_FG    = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0]  RST_BG    = 32'h0000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS  = 3'd0,
    CFG_ROWS  = 3'd1,
    CFG_GW    = 3'd2,
    CFG_GH    = 3'd3,
    CFG_COUNT = 3'd4,
    CFG_TAB   = 3'd5,
    CFG_FG    = 3'd6,
    CFG_BG    = 3'd7
  } cfg_idx_t;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Result operations
  localparam logic [OP_W-1:0] OP_DRAW   = 2'd0;
  localparam logic [OP_W-1:0] OP_BLANK  = 2'd1;
  localparam logic [OP_W-1:0] OP_SCROLL = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Control characters
  localparam logic [CODE_W-1:0] CH_BEL = 8'h07;
  localparam logic [CODE_W-1:0] CH_BS  = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CODE_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CODE_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;

  // Character classes
  typedef enum logic [2:0] {
    CC_BEL,
    CC_BS,
    CC_LF,
    CC_CR,
    CC_TAB,
    CC_FF,
    CC_VT,
    CC_PRINT
  } cls_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic latch;
    logic store_wr;
    logic calc_dims;
    logic emit_clear;
    logic do_scroll;
    logic scroll_last;
    logic step_back;
    logic div_start;
    logic apply;
    logic calc_prod;
    logic emit_row;
    logic advance;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] command;
    cls_t             cls;
    logic             need_scroll;
    logic             cursor_zero;
    logic             lastrow_zero;
    logic             div_busy;
    logic             row_last;
    logic             out_free;
  } ctrl_sts_t;

endpackage

/* rtl/tcr_if.sv */
// Valid/ready channel interfaces for the command input and the row-write results.
`timescale 1ns / 1ps
interface tcr_cmd_if;
  import tcr_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CODE_W-1:0]   char_code;
  logic [GSEL_W-1:0]   glyph_select;
  logic [GROW_W-1:0]   glyph_row;
  logic [DATA_W-1:0]   row_pattern;

  modport source (output valid, command, char_code, glyph_select, glyph_row, row_pattern,
                  input ready);
  modport sink   (input valid, command, char_code, glyph_select, glyph_row, row_pattern,
                  output ready);
endinterface

interface tcr_res_if;
  import tcr_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [DATA_W-1:0]  pattern_bits;
  logic [DATA_W-1:0]  set_color;
  logic [DATA_W-1:0]  clear_color;
  logic               last;

  modport source (output valid, operation, pixel_x, pixel_y, pattern_bits, set_color,
                  clear_color, last, input ready);
  modport sink   (input valid, operation, pixel_x, pixel_y, pattern_bits, set_color,
                  clear_color, last, output ready);
endinterface

/* rtl/text_console_renderer_unit.sv */
// Top level of the text console renderer: controller, datapath and channel wiring.
`timescale 1ns / 1ps
// The renderer takes one command beat at a time on in_cmd: put a character, load one
// 32-bit row of a glyph into the on-chip glyph store, or clear the screen. It keeps a
// linear cursor cell and a return column, and turns put and clear commands into row-write
// beats on out_res: a scroll before a character whose cursor has run past the screen, one
// draw beat per glyph pixel row for a printable code, one blank beat per pixel row for
// a backspace, one clear beat for a clear. The last beat of each command carries last.
// Items are worked one at a time. A clear waits until the output is free. The cursor
// divider resolves cell number by column count two quotient bits per cycle in 9 steps.
// The result register lets the next command enter while the final beat still waits
// downstream. Configuration registers are written on the cfg_ port; the user must
// write them only between commands, as the block itself does not enforce this. Glyph
// store entries hold no value until loaded.
module text_console_renderer_unit #(
  parameter int MAX_GLYPHS       = tcr_pkg::DEF_MAX_GLYPHS,
  parameter int MAX_GLYPH_HEIGHT = tcr_pkg::DEF_MAX_GLYPH_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tcr_cmd_if.sink                        in_cmd,
  tcr_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcr_pkg::DATA_W-1:0]     cfg_data
);
  import tcr_pkg::*;

  ctrl_cmd_t ctl_cmd;
  ctrl_sts_t ctl_sts;

  // The controller owns the sequencing; it only sees status flags from the datapath.
  tcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_cmd.ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // The datapath holds the configuration, cursor, glyph store and the result register.
  tcr_dp #(
    .MAX_GLYPHS       (MAX_GLYPHS),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_cmd.command),
    .in_char_code     (in_cmd.char_code),
    .in_glyph_select  (in_cmd.glyph_select),
    .in_glyph_row     (in_cmd.glyph_row),
    .in_row_pattern   (in_cmd.row_pattern),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (ctl_cmd),
    .sts              (ctl_sts),
    .out_valid        (out_res.valid),
    .out_ready        (out_res.ready),
    .out_operation    (out_res.operation),
    .out_pixel_x      (out_res.pixel_x),
    .out_pixel_y      (out_res.pixel_y),
    .out_pattern_bits (out_res.pattern_bits),
    .out_set_color    (out_res.set_color),
    .out_clear_color  (out_res.clear_color),
    .out_last         (out_res.last)
  );

endmodule

/* rtl/tcr_div.sv */
// Iterative cursor divider: cell number by column count, two quotient bits per cycle.
`timescale 1ns / 1ps
module tcr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcr_pkg::CURSOR_W-1:0]  dividend,
  input  logic [tcr_pkg::COL_W-1:0]     divisor,
  output logic                          busy,
  output logic [tcr_pkg::CURSOR_W-1:0]  quotient,
  output logic [tcr_pkg::COL_W-1:0]     remainder
);
  import tcr_pkg::*;

  localparam int QW    = CURSOR_W + 1;
  localparam int STEPS = QW / 2;
  localparam int CW    = $clog2(STEPS);

  logic [QW-1:0]    quo_r, quo_nxt;
  logic [COL_W-1:0] rem_r, rem_nxt;
  logic [COL_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [COL_W:0]   part;

  // Two restoring steps per cycle on a 9-bit partial remainder.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    part    = '0;
    for (int i = 0; i < 2; i++) begin
      part    = {rem_nxt, quo_nxt[QW-1]};
      quo_nxt = {quo_nxt[QW-2:0], 1'b0};
      if (part >= {1'b0, dvs_r}) begin
        part       = part - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = part[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {1'b0, dividend};
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r[CURSOR_W-1:0];
  assign remainder = rem_r;

endmodule

/* rtl/tcr_ctrl.sv */
// Sequencing state machine of the console renderer.
`timescale 1ns / 1ps
module tcr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcr_pkg::ctrl_sts_t  sts,
  output tcr_pkg::ctrl_cmd_t  cmd
);
  import tcr_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_CLEAR  = 9'b000000100,
    S_CHECK  = 9'b000001000,
    S_STEP   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_ROWS   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.command)
          CMD_LOAD: begin
            cmd.store_wr = 1'b1;
            state_nxt    = S_IDLE;
          end
          CMD_CLEAR: begin
            state_nxt = S_CLEAR;
          end
          CMD_PUT: begin
            cmd.calc_dims = 1'b1;
            state_nxt     = S_CHECK;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          cmd.emit_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_CHECK: begin
        if (!sts.need_scroll) begin
          state_nxt = S_STEP;
        end else if (sts.out_free) begin
          cmd.do_scroll   = 1'b1;
          cmd.scroll_last = !((sts.cls == CC_PRINT) ||
                              ((sts.cls == CC_BS) && !sts.lastrow_zero));
          state_nxt       = S_STEP;
        end
      end
      S_STEP: begin
        case (sts.cls)
          CC_BEL: begin
            state_nxt = S_IDLE;
          end
          CC_FF, CC_TAB: begin
            cmd.apply = 1'b1;
            state_nxt = S_IDLE;
          end
          CC_BS: begin
            if (sts.cursor_zero) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.step_back = 1'b1;
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.calc_prod = 1'b1;
        if (sts.cls == CC_BS || sts.cls == CC_PRINT) begin
          state_nxt = S_ROWS;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.apply = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ROWS: begin
        if (sts.out_free) begin
          cmd.emit_row = 1'b1;
          if (sts.row_last) begin
            cmd.advance = (sts.cls == CC_PRINT);
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/tcr_dp.sv */
// Datapath: registers, cursor arithmetic, glyph store and result register.
`timescale 1ns / 1ps
module tcr_dp #(
  parameter int MAX_GLYPHS       = tcr_pkg::DEF_MAX_GLYPHS,
  parameter int MAX_GLYPH_HEIGHT = tcr_pkg::DEF_MAX_GLYPH_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item payload
  input  logic [tcr_pkg::CMD_W-1:0]         in_command,
  input  logic [tcr_pkg::CODE_W-1:0]        in_char_code,
  input  logic [tcr_pkg::GSEL_W-1:0]        in_glyph_select,
  input  logic [tcr_pkg::GROW_W-1:0]        in_glyph_row,
  input  logic [tcr_pkg::DATA_W-1:0]        in_row_pattern,
  // configuration
  input  logic                              cfg_we,
  input  logic [tcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcr_pkg::DATA_W-1:0]        cfg_data,
  // controller
  input  tcr_pkg::ctrl_cmd_t                cmd,
  output tcr_pkg::ctrl_sts_t                sts,
  // result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tcr_pkg::OP_W-1:0]          out_operation,
  output logic [tcr_pkg::PIX_W-1:0]         out_pixel_x,
  output logic [tcr_pkg::PIX_W-1:0]         out_pixel_y,
  output logic [tcr_pkg::DATA_W-1:0]        out_pattern_bits,
  output logic [tcr_pkg::DATA_W-1:0]        out_set_color,
  output logic [tcr_pkg::DATA_W-1:0]        out_clear_color,
  output logic                              out_last
);
  import tcr_pkg::*;

  localparam int DEPTH = MAX_GLYPHS * MAX_GLYPH_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;

  // Configuration registers
  logic [COL_W-1:0]   cols_r, rows_r, tab_r;
  logic [GDIM_W-1:0]  gw_r, gh_r;
  logic [COUNT_W-1:0] count_r;
  logic [DATA_W-1:0]  fg_r, bg_r;

  // Latched item
  logic [CMD_W-1:0]   cmd_code_r;
  logic [CODE_W-1:0]  code_r;
  logic [GSEL_W-1:0]  gsel_r;
  logic [GROW_W-1:0]  grow_r;
  logic [DATA_W-1:0]  pat_r;

  // Working state
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic [COL_W-1:0]    ret_r, ret_nxt;
  logic [CELLS_W-1:0]  cells_r, lastrow_r;
  logic [PIX_W-1:0]    px_r, pybase_r;
  logic [CURSOR_W-1:0] qc_r;
  logic [RW-1:0]       y_r, y_inc;
  logic [DATA_W-1:0]   rd_r;
  logic [DATA_W-1:0]   mem [DEPTH];

  logic [COL_W-1:0]    cols_eff, rows_eff;
  logic [GDIM_W-1:0]   gw_eff, gh_eff;
  logic [DATA_W-1:0]   pat_mask;
  cls_t                cls;
  logic                is_print;
  logic                row_last;
  logic [CODE_W-1:0]   gsel_draw, gidx;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [RW-1:0]       rd_row;
  logic                wr_en, rd_en;

  logic                div_busy;
  logic [CURSOR_W-1:0] div_q;
  logic [COL_W-1:0]    div_rem;

  logic                out_valid_r, out_valid_nxt;
  logic                out_free, emit_any;
  logic [OP_W-1:0]     op_r;
  logic [PIX_W-1:0]    x_r, yout_r;
  logic [DATA_W-1:0]   bits_r, setc_r, clrc_r;
  logic                last_r;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= RST_COLS;
      rows_r  <= RST_ROWS;
      gw_r    <= RST_GW;
      gh_r    <= RST_GH;
      count_r <= RST_COUNT;
      tab_r   <= RST_TAB;
      fg_r    <= RST_FG;
      bg_r    <= RST_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS:  cols_r  <= cfg_data[COL_W-1:0];
        CFG_ROWS:  rows_r  <= cfg_data[COL_W-1:0];
        CFG_GW:    gw_r    <= cfg_data[GDIM_W-1:0];
        CFG_GH:    gh_r    <= cfg_data[GDIM_W-1:0];
        CFG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        CFG_TAB:   tab_r   <= cfg_data[COL_W-1:0];
        CFG_FG:    fg_r    <= cfg_data;
        CFG_BG:    bg_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero sizes act as one; glyph sizes saturate at the store limits.
  assign cols_eff = (cols_r == '0) ? COL_W'(1) : cols_r;
  assign rows_eff = (rows_r == '0) ? COL_W'(1) : rows_r;
  assign gw_eff   = (gw_r == '0) ? GDIM_W'(1) :
                    (gw_r > GDIM_W'(DATA_W)) ? GDIM_W'(DATA_W) : gw_r;
  assign gh_eff   = (gh_r == '0) ? GDIM_W'(1) :
                    (gh_r > GDIM_W'(MAX_GLYPH_HEIGHT)) ? GDIM_W'(MAX_GLYPH_HEIGHT) : gh_r;
  assign pat_mask = {DATA_W{1'b1}} << (GDIM_W'(DATA_W) - gw_eff);

  // ---- item latch ----
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_code_r <= in_command;
      code_r     <= in_char_code;
      gsel_r     <= in_glyph_select;
      grow_r     <= in_glyph_row;
      pat_r      <= in_row_pattern;
    end
  end

  always_comb begin
    case (code_r)
      CH_BEL:  cls = CC_BEL;
      CH_BS:   cls = CC_BS;
      CH_LF:   cls = CC_LF;
      CH_CR:   cls = CC_CR;
      CH_TAB:  cls = CC_TAB;
      CH_FF:   cls = CC_FF;
      CH_VT:   cls = CC_VT;
      default: cls = CC_PRINT;
    endcase
  end
  assign is_print = (cls == CC_PRINT);

  // ---- screen size products ----
  always_ff @(posedge clk) begin
    if (cmd.calc_dims) begin
      cells_r   <= CELLS_W'(cols_eff * rows_eff);
      lastrow_r <= CELLS_W'((rows_eff - 1'b1) * cols_eff);
    end
  end

  // ---- cursor and return column ----
  always_comb begin
    cursor_nxt = cursor_r;
    ret_nxt    = ret_r;
    if (cmd.emit_clear) begin
      cursor_nxt = '0;
    end
    if (cmd.do_scroll) begin
      cursor_nxt = CURSOR_W'(lastrow_r);
    end
    if (cmd.step_back) begin
      cursor_nxt = cursor_r - 1'b1;
    end
    if (cmd.apply) begin
      case (cls)
        CC_TAB:  cursor_nxt = cursor_r + CURSOR_W'(tab_r);
        CC_LF:   cursor_nxt = qc_r + CURSOR_W'(cols_eff) + CURSOR_W'(ret_r);
        CC_CR:   cursor_nxt = qc_r + CURSOR_W'(ret_r);
        CC_FF:   ret_nxt = '0;
        CC_VT:   ret_nxt = div_rem;
        default: ;
      endcase
    end
    if (cmd.advance) begin
      cursor_nxt = cursor_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      ret_r    <= '0;
    end else begin
      cursor_r <= cursor_nxt;
      ret_r    <= ret_nxt;
    end
  end

  tcr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (cursor_nxt),
    .divisor   (cols_eff),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Column and row of the cell turned into pixel positions and a row base cell.
  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      px_r     <= PIX_W'(div_rem * gw_eff);
      pybase_r <= PIX_W'(div_q * gh_eff);
      qc_r     <= CURSOR_W'(div_q * cols_eff);
    end
  end

  // ---- glyph row counter ----
  assign y_inc    = y_r + 1'b1;
  assign row_last = (GDIM_W'(y_r) == gh_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.calc_prod) begin
      y_r <= '0;
    end else if (cmd.emit_row) begin
      y_r <= y_inc;
    end
  end

  // ---- glyph store ----
  assign gsel_draw = ({1'b0, code_r} < count_r) ? code_r : '0;
  assign gidx      = gsel_draw & CODE_W'(MAX_GLYPHS - 1);
  assign rd_row    = cmd.calc_prod ? '0 : y_inc;
  assign rd_addr   = AW'(gidx) * AW'(MAX_GLYPH_HEIGHT) + AW'(rd_row);
  assign rd_en     = cmd.calc_prod || (cmd.emit_row && !row_last);
  assign wr_addr   = AW'(gsel_r) * AW'(MAX_GLYPH_HEIGHT) + AW'(grow_r);
  assign wr_en     = cmd.store_wr &&
                     ({1'b0, gsel_r} < (GSEL_W + 1)'(MAX_GLYPHS)) &&
                     ({1'b0, grow_r} < (GROW_W + 1)'(MAX_GLYPH_HEIGHT));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= pat_r;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // ---- result register ----
  assign out_free      = !out_valid_r || out_ready;
  assign emit_any      = cmd.emit_clear || cmd.do_scroll || cmd.emit_row;
  assign out_valid_nxt = emit_any ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_clear) begin
      op_r   <= OP_CLEAR;
      x_r    <= '0;
      yout_r <= '0;
      bits_r <= '0;
      setc_r <= '0;
      clrc_r <= '0;
      last_r <= 1'b1;
    end else if (cmd.do_scroll) begin
      op_r   <= OP_SCROLL;
      x_r    <= '0;
      yout_r <= '0;
      bits_r <= '0;
      setc_r <= '0;
      clrc_r <= '0;
      last_r <= cmd.scroll_last;
    end else if (cmd.emit_row) begin
      op_r   <= is_print ? OP_DRAW : OP_BLANK;
      x_r    <= px_r;
      yout_r <= pybase_r + PIX_W'(y_r);
      bits_r <= is_print ? (rd_r & pat_mask) : '0;
      setc_r <= is_print ? fg_r : '0;
      clrc_r <= is_print ? bg_r : '0;
      last_r <= row_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_operation    = op_r;
  assign out_pixel_x      = x_r;
  assign out_pixel_y      = yout_r;
  assign out_pattern_bits = bits_r;
  assign out_set_color    = setc_r;
  assign out_clear_color  = clrc_r;
  assign out_last         = last_r;

  // ---- status ----
  assign sts.command      = cmd_code_r;
  assign sts.cls          = cls;
  assign sts.need_scroll  = (cursor_r >= CURSOR_W'(cells_r));
  assign sts.cursor_zero  = (cursor_r == '0);
  assign sts.lastrow_zero = (lastrow_r == '0);
  assign sts.div_busy     = div_busy;
  assign sts.row_last     = row_last;
  assign sts.out_free     = out_free;

endmodule
